// File: rtl/i2cm_pkg.sv
// Package for the I2C master bit engine: command codes, field widths,
// engine state type and segment count table. No dependencies.
package i2cm_pkg;

    localparam int ACT_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int HALF_W  = 16;
    localparam int PHASE_W = 6;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd250;

    typedef enum logic [ACT_W-1:0] {
        CMD_IDLE    = 4'd0,
        CMD_START   = 4'd1,
        CMD_STOP    = 4'd2,
        CMD_WRITE   = 4'd3,
        CMD_READ    = 4'd4,
        CMD_WAITACK = 4'd5,
        CMD_ACK     = 4'd6,
        CMD_NACK    = 4'd7,
        CMD_PROBE   = 4'd8
    } t_cmd;

    // pin levels and data that segments modify
    typedef struct packed {
        logic              scl;
        logic              sda;
        logic [BYTE_W-1:0] shift;
        logic              ack;
    } t_eng;

    function automatic logic [PHASE_W-1:0] seg_count(input t_cmd c);
        case (c)
            CMD_START:   seg_count = 6'd3;
            CMD_STOP:    seg_count = 6'd2;
            CMD_WRITE:   seg_count = 6'd16;
            CMD_READ:    seg_count = 6'd16;
            CMD_WAITACK: seg_count = 6'd3;
            CMD_ACK:     seg_count = 6'd3;
            CMD_NACK:    seg_count = 6'd3;
            CMD_PROBE:   seg_count = 6'd24;
            default:     seg_count = 6'd0;
        endcase
    endfunction

endpackage

// File: rtl/i2cm_req_if.sv
// Request channel of the I2C master bit engine: one tick with line samples
// and an optional command. Depends on i2cm_pkg.
interface i2cm_req_if;
    import i2cm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [BYTE_W-1:0]   data_byte;
    logic                sda_sample;
    logic                scl_sample;

    modport source (output valid, action, data_byte, sda_sample, scl_sample, input ready);
    modport sink   (input valid, action, data_byte, sda_sample, scl_sample, output ready);
endinterface

// File: rtl/i2cm_res_if.sv
// Result channel of the I2C master bit engine: pin drives and status per tick.
// Depends on i2cm_pkg.
interface i2cm_res_if;
    import i2cm_pkg::*;

    logic                valid;
    logic                ready;
    logic                scl_drive;
    logic                sda_drive;
    logic                busy_res;
    logic                done_res;
    logic [BYTE_W-1:0]   read_data;
    logic                no_ack;

    modport source (output valid, scl_drive, sda_drive, busy_res, done_res, read_data, no_ack,
                    input ready);
    modport sink   (input valid, scl_drive, sda_drive, busy_res, done_res, read_data, no_ack,
                    output ready);
endinterface

// File: rtl/i2c_master_bit_engine_top.sv
// I2C master bit engine top level: input register, segment sequencer, result register.
// Depends on i2cm_pkg, i2cm_req_if, i2cm_res_if.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        action, data_byte, sda_sample, scl_sample
//  o_res     out  valid/ready        scl_drive, sda_drive, busy_res, done_res, read_data, no_ack
//  cfg       in   i_cfg_we           i_cfg_wdata = half_period_ticks
//
// One request per cycle sustained while o_res is not stalled; a result passes the input register
// and then the result register around the sequencer before it is offered.
// Synchronous active-low reset; half period returns to 250, pins to released.
// A stalled result register holds the input register, which then deasserts ready.
module i2c_master_bit_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [i2cm_pkg::HALF_W-1:0]  i_cfg_wdata,
    i2cm_req_if.sink                     i_req,
    i2cm_res_if.source                   o_res
);
    import i2cm_pkg::*;

    logic                w_half_zero;
    logic [HALF_W-1:0]   r_half_ticks;

    logic                r_in_valid;
    logic [ACT_W-1:0]    r_act;
    logic [BYTE_W-1:0]   r_dbyte;
    logic                r_sda_in;
    logic                r_scl_in;

    t_cmd                r_cmd,   n_cmd;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [HALF_W-1:0]   r_timer, n_timer;
    t_eng                r_eng,   n_eng;
    logic [BYTE_W-1:0]   r_read,  n_read;
    logic                n_done;

    logic                r_out_valid;
    logic                w_adv;
    logic                w_step;
    logic [HALF_W-1:0]   w_load;
    logic [PHASE_W-1:0]  w_next_phase;
    logic                w_act_ok;

    function automatic t_eng seg_start(input t_eng s, input logic [PHASE_W-1:0] k);
        t_eng r;
        r = s;
        if (k == 6'd0) begin
            r.scl = 1'b1;
            r.sda = 1'b1;
        end else if (k == 6'd1) begin
            r.sda = 1'b0;
        end else begin
            r.scl = 1'b0;
        end
        return r;
    endfunction

    function automatic t_eng seg_stop(input t_eng s, input logic [PHASE_W-1:0] k);
        t_eng r;
        r = s;
        if (k == 6'd0) begin
            r.sda = 1'b0;
            r.scl = 1'b1;
        end else begin
            r.sda = 1'b1;
        end
        return r;
    endfunction

    function automatic t_eng seg_write(input t_eng s, input logic [PHASE_W-1:0] k);
        t_eng r;
        r = s;
        if (!k[0]) begin
            if (k != 6'd0) r.scl = 1'b0;
            r.sda = s.shift[BYTE_W-1];
        end else begin
            r.scl   = 1'b1;
            r.shift = {s.shift[BYTE_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_eng seg_read(input t_eng s, input logic [PHASE_W-1:0] k,
                                      input logic sda_in);
        t_eng r;
        r = s;
        if (!k[0]) begin
            r.scl = 1'b1;
        end else begin
            r.shift = {s.shift[BYTE_W-2:0], sda_in};
            r.scl   = 1'b0;
        end
        return r;
    endfunction

    function automatic t_eng seg_wack(input t_eng s, input logic [PHASE_W-1:0] k,
                                      input logic sda_in);
        t_eng r;
        r = s;
        if (k == 6'd0) begin
            r.sda = 1'b1;
        end else if (k == 6'd1) begin
            r.scl = 1'b1;
        end else begin
            r.ack = sda_in;
            r.scl = 1'b0;
        end
        return r;
    endfunction

    function automatic t_eng seg_clock(input t_eng s, input logic [PHASE_W-1:0] k,
                                       input logic first_sda);
        t_eng r;
        r = s;
        if (k == 6'd0) begin
            r.sda = first_sda;
        end else if (k == 6'd1) begin
            r.scl = 1'b1;
        end else begin
            r.scl = 1'b0;
        end
        return r;
    endfunction

    function automatic t_eng apply_seg(input t_cmd c, input logic [PHASE_W-1:0] k,
                                       input logic sda_in, input t_eng s);
        t_eng r;
        r = s;
        case (c)
            CMD_START:   r = seg_start(s, k);
            CMD_STOP:    r = seg_stop(s, k);
            CMD_WRITE:   r = seg_write(s, k);
            CMD_READ:    r = seg_read(s, k, sda_in);
            CMD_WAITACK: r = seg_wack(s, k, sda_in);
            CMD_ACK:     r = seg_clock(s, k, 1'b0);
            CMD_NACK:    r = seg_clock(s, k, 1'b1);
            CMD_PROBE: begin
                if (k < 6'd3) begin
                    r = seg_start(s, k);
                end else if (k < 6'd19) begin
                    r = seg_write(s, k - 6'd3);
                end else if (k < 6'd22) begin
                    if (k == 6'd19) begin
                        r.scl = 1'b0;
                        r.sda = 1'b1;
                    end
                    r = seg_wack(r, k - 6'd19, sda_in);
                end else begin
                    r = seg_stop(s, k - 6'd22);
                end
            end
            default:     r = s;
        endcase
        return r;
    endfunction

    // handshake
    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_step      = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_ticks <= HALF_RESET;
        end else if (i_cfg_we) begin
            r_half_ticks <= i_cfg_wdata;
        end
    end
    assign w_half_zero = (r_half_ticks == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_act    <= i_req.action;
            r_dbyte  <= i_req.data_byte;
            r_sda_in <= i_req.sda_sample;
            r_scl_in <= i_req.scl_sample;
        end
    end

    assign w_load       = w_half_zero ? '0 : r_half_ticks - 16'd1;
    assign w_next_phase = r_phase + 6'd1;
    assign w_act_ok     = (r_act >= ACT_W'(CMD_START)) && (r_act <= ACT_W'(CMD_PROBE));

    // next command, phase, timer and done flag
    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_timer = r_timer;
        n_done  = 1'b0;
        if (r_cmd == CMD_IDLE) begin
            if (w_act_ok) begin
                if (t_cmd'(r_act) == CMD_PROBE && !(r_sda_in && r_scl_in)) begin
                    n_done = 1'b1;
                end else begin
                    n_cmd   = t_cmd'(r_act);
                    n_phase = '0;
                    n_timer = w_load;
                end
            end
        end else if (r_timer != '0) begin
            n_timer = r_timer - 16'd1;
        end else if (w_next_phase < seg_count(r_cmd)) begin
            n_phase = w_next_phase;
            n_timer = w_load;
        end else begin
            n_cmd   = CMD_IDLE;
            n_phase = '0;
            n_done  = 1'b1;
        end
    end

    // pins and data
    always_comb begin
        t_eng s;
        s      = r_eng;
        n_eng  = r_eng;
        n_read = r_read;
        if (r_cmd == CMD_IDLE) begin
            if (w_act_ok) begin
                if (t_cmd'(r_act) == CMD_PROBE && !(r_sda_in && r_scl_in)) begin
                    n_eng.ack = 1'b1;
                end else begin
                    if (t_cmd'(r_act) == CMD_WRITE || t_cmd'(r_act) == CMD_PROBE) begin
                        s.shift = r_dbyte;
                    end else if (t_cmd'(r_act) == CMD_READ) begin
                        s.shift = '0;
                    end
                    n_eng = apply_seg(t_cmd'(r_act), '0, r_sda_in, s);
                end
            end
        end else if (r_timer == '0) begin
            if (w_next_phase < seg_count(r_cmd)) begin
                n_eng = apply_seg(r_cmd, w_next_phase, r_sda_in, r_eng);
            end else if (r_cmd == CMD_WRITE) begin
                n_eng.scl = 1'b0;
                n_eng.sda = 1'b1;
            end else if (r_cmd == CMD_ACK) begin
                n_eng.sda = 1'b1;
            end else if (r_cmd == CMD_READ) begin
                n_read = r_eng.shift;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_IDLE;
            r_phase     <= '0;
            r_timer     <= '0;
            r_eng       <= '{scl: 1'b1, sda: 1'b1, shift: '0, ack: 1'b0};
            r_read      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_cmd   <= n_cmd;
                r_phase <= n_phase;
                r_timer <= n_timer;
                r_eng   <= n_eng;
                r_read  <= n_read;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            o_res.scl_drive <= n_eng.scl;
            o_res.sda_drive <= n_eng.sda;
            o_res.busy_res  <= (n_cmd != CMD_IDLE);
            o_res.done_res  <= n_done;
            o_res.read_data <= n_read;
            o_res.no_ack    <= n_eng.ack;
        end
    end

    assign o_res.valid = r_out_valid;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.done_res) |-> !o_res.busy_res)
        else $error("done result reports busy");

    a_idle_timer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_IDLE) |-> (r_timer == '0))
        else $error("half timer running while idle");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != CMD_IDLE) |-> (r_phase < seg_count(r_cmd)))
        else $error("segment index beyond command length");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed request produced no result");

endmodule
